>>> rtl/core/pulse_oximeter_spo2_bpm_unit_defines.svh
// assertion macros used by the top-level unit
`ifndef PULSE_OXIMETER_SPO2_BPM_UNIT_DEFINES_SVH
`define PULSE_OXIMETER_SPO2_BPM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define POS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition must never be seen out of reset
`define POS_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define POS_ASSERT(name, prop, msg)
`define POS_NEVER(name, cond, msg)
`endif

`endif

>>> rtl/core/pos_pkg.sv
package pos_pkg;

   // field widths
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 16;
   localparam int DC_BITS     = 16;
   localparam int NUM_BITS    = 20;
   localparam int SPO2_BITS   = 7;
   localparam int RATE_BITS   = 8;

   // ratio in unsigned Q4.12
   localparam int RATIO_BITS = 16;
   localparam int FRAC_BITS  = 12;

   // divider sizing
   localparam int PROD_W = SAMPLE_BITS + DC_BITS;
   localparam int DIV_W  = PROD_W + RATIO_BITS;
   localparam int QCNT_W = $clog2(RATIO_BITS);

   // spo2 line fit
   localparam int SPO2_ACC_W = 24;
   localparam int SPO2_INT_W = SPO2_ACC_W - FRAC_BITS;

   localparam logic [NUM_BITS-1:0]   NUM_RESET  = NUM_BITS'(30303);
   localparam logic [RATIO_BITS-1:0] R_LOW      = RATIO_BITS'(1638);
   localparam logic [RATIO_BITS-1:0] Q_ONE      = RATIO_BITS'(4096);
   localparam logic [SPO2_ACC_W-1:0] BAND_BASE  = SPO2_ACC_W'(110 * 4096);
   localparam logic [SPO2_ACC_W-1:0] BAND_SLOPE = SPO2_ACC_W'(25);
   localparam logic [SPO2_ACC_W-1:0] OUT_BASE   = SPO2_ACC_W'(113 * 4096);
   localparam logic [SPO2_ACC_W-1:0] OUT_SLOPE  = SPO2_ACC_W'(35);
   localparam logic [SPO2_BITS-1:0]  SPO2_MAX   = SPO2_BITS'(100);
   localparam logic [RATE_BITS-1:0]  RATE_MAX   = '1;
   localparam logic [1:0]            CROSS_CLOSE   = 2'd3;
   localparam logic [1:0]            CROSS_RESTART = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_RDIV,
      ST_RWAIT,
      ST_SPO2,
      ST_CROSS,
      ST_BWAIT,
      ST_RATE,
      ST_DONE
   } pos_state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_start;
      logic div_rate;
      logic spo2_wr;
      logic cross_wr;
      logic rate_wr;
      logic out_wr;
   } pos_cmd_type;

   typedef struct packed {
      logic err;
      logic close;
      logic div_busy;
      logic div_done;
      logic out_free;
   } pos_stat_type;

endpackage

>>> rtl/core/pulse_oximeter_spo2_bpm_unit.sv
// Pulse oximeter unit: each request carries one red/infrared AC and DC sample and
// yields one response with SpO2 (ratio of ratios in Q4.12, line fit, clamped 0..100,
// held when a DC value or the infrared peak-to-peak is zero) and the heart rate,
// recomputed as bpm_numerator / period samples (saturated to 255) whenever a third
// red AC zero crossing closes a period. Requests are taken one at a time and use the
// shared 16-step restoring divider for the ratio and, when a period closes, for the
// rate. A zero DC value or infrared peak-to-peak skips the ratio pass. A finished
// response waits in an output register, so the next request can be accepted before
// it is taken. Write bpm_numerator only while no request is in flight.
`include "pulse_oximeter_spo2_bpm_unit_defines.svh"

module pulse_oximeter_spo2_bpm_unit
   import pos_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_red_ac,
   input  logic signed [SAMPLE_BITS-1:0] req_ir_ac,
   input  logic [DC_BITS-1:0]            req_red_dc,
   input  logic [DC_BITS-1:0]            req_ir_dc,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SPO2_BITS-1:0]          rsp_spo2_percent,
   output logic [RATE_BITS-1:0]          rsp_heart_rate,
   output logic                          rsp_rate_updated,
   output logic                          rsp_ratio_error,
   input  logic                          csr_wr_en,
   input  logic [NUM_BITS-1:0]           csr_wr_data
);

   pos_cmd_type  cmd;
   pos_stat_type stat;
   logic         req_fire;

   assign req_fire = req_valid && req_ready;

   // sequencer
   pos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // state, arithmetic and response register
   pos_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_red_ac       (req_red_ac),
      .req_ir_ac        (req_ir_ac),
      .req_red_dc       (req_red_dc),
      .req_ir_dc        (req_ir_dc),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_spo2_percent (rsp_spo2_percent),
      .rsp_heart_rate   (rsp_heart_rate),
      .rsp_rate_updated (rsp_rate_updated),
      .rsp_ratio_error  (rsp_ratio_error)
   );

   // checks
   `POS_ASSERT(a_one_request_at_a_time, req_fire |=> !req_ready, "request taken while busy")
   `POS_NEVER(a_div_start_while_busy, cmd.div_start && stat.div_busy, "divider restarted")
   `POS_ASSERT(a_spo2_in_range, rsp_valid |-> (rsp_spo2_percent <= SPO2_MAX), "spo2 above 100")

endmodule

>>> rtl/core/pos_div.sv
module pos_div
   import pos_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_W-1:0]      dividend,
   input  logic [PROD_W-1:0]     divisor,
   output logic                  busy,
   output logic                  done,
   output logic [RATIO_BITS-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      dsh_ff, dsh_in;
   logic [RATIO_BITS-1:0] quo_ff, quo_in;
   logic                  ge;
   logic                  last;

   // one restoring step a cycle, quotient bit from the top down
   assign ge   = rem_ff >= dsh_ff;
   assign last = cnt_ff == QCNT_W'(RATIO_BITS - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dsh_in  = {1'b0, divisor, {(RATIO_BITS - 1){1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[RATIO_BITS-2:0], ge};
         cnt_in = cnt_ff + QCNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/pos_datapath.sv
module pos_datapath
   import pos_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  pos_cmd_type                   cmd,
   output pos_stat_type                  stat,
   input  logic signed [SAMPLE_BITS-1:0] req_red_ac,
   input  logic signed [SAMPLE_BITS-1:0] req_ir_ac,
   input  logic [DC_BITS-1:0]            req_red_dc,
   input  logic [DC_BITS-1:0]            req_ir_dc,
   input  logic                          csr_wr_en,
   input  logic [NUM_BITS-1:0]           csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SPO2_BITS-1:0]          rsp_spo2_percent,
   output logic [RATE_BITS-1:0]          rsp_heart_rate,
   output logic                          rsp_rate_updated,
   output logic                          rsp_ratio_error
);

   logic [NUM_BITS-1:0]           num_ff;
   logic [DC_BITS-1:0]            rdc_ff, idc_ff;
   logic signed [SAMPLE_BITS-1:0] red_max_ff, red_min_ff, ir_max_ff, ir_min_ff;
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic                          cross_ff, cross_in;
   logic [1:0]                    cnt_ff, cnt_next;
   logic [COUNT_BITS-1:0]         period_ff;
   logic [RATE_BITS-1:0]          last_rate_ff;
   logic [SPO2_BITS-1:0]          last_spo2_ff, spo2_in;
   logic                          err_ff, err_in;
   logic                          upd_ff;
   logic                          sat_ff, sat_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [PROD_W-1:0]             den_ff, den_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SPO2_BITS-1:0]          rsp_spo2_ff;
   logic [RATE_BITS-1:0]          rsp_rate_ff;
   logic                          rsp_upd_ff, rsp_err_ff;

   logic [SAMPLE_BITS-1:0]        ptp_r, ptp_i;
   logic                          prev_neg, prev_pos, cur_neg, cur_pos;
   logic [DIV_W-1:0]              ratio_num, rate_num;
   logic                          sat_ratio, sat_rate;
   logic [DIV_W-1:0]              div_dividend;
   logic [PROD_W-1:0]             div_divisor;
   logic                          div_busy, div_done;
   logic [RATIO_BITS-1:0]         div_quo;
   logic [RATIO_BITS-1:0]         ratio;
   logic                          inband;
   logic [SPO2_ACC_W-1:0]         r_ext;
   logic signed [SPO2_ACC_W-1:0]  acc;
   logic [SPO2_INT_W-1:0]         spo2_int;

   // peak to peak of both ac channels, peaks always straddle zero
   assign ptp_r = red_max_ff - red_min_ff;
   assign ptp_i = ir_max_ff - ir_min_ff;

   // zero crossing of red ac against the previous sample
   assign prev_neg = prev_ff[SAMPLE_BITS-1];
   assign prev_pos = !prev_ff[SAMPLE_BITS-1] && (prev_ff != '0);
   assign cur_neg  = req_red_ac[SAMPLE_BITS-1];
   assign cur_pos  = !req_red_ac[SAMPLE_BITS-1] && (req_red_ac != '0);
   assign cross_in = (prev_neg && cur_pos) || (prev_pos && cur_neg) || (req_red_ac == '0);

   // crossing count and period close
   assign cnt_next = cross_ff ? cnt_ff + 2'd1 : cnt_ff;

   // ratio products
   assign prod_in = PROD_W'(ptp_r) * PROD_W'(idc_ff);
   assign den_in  = PROD_W'(rdc_ff) * PROD_W'(ptp_i);
   assign err_in  = (rdc_ff == '0) || (idc_ff == '0) || (ptp_i == '0);

   // saturation checks before the divider runs
   assign ratio_num = DIV_W'({prod_ff, {FRAC_BITS{1'b0}}});
   assign rate_num  = DIV_W'(num_ff);
   assign sat_ratio = ratio_num >= {den_ff, {RATIO_BITS{1'b0}}};
   assign sat_rate  = rate_num >= DIV_W'({period_ff, {RATE_BITS{1'b0}}});
   assign sat_in    = cmd.div_rate ? sat_rate : sat_ratio;

   assign div_dividend = cmd.div_rate ? rate_num : ratio_num;
   assign div_divisor  = cmd.div_rate ? PROD_W'(period_ff) : den_ff;

   pos_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // spo2 from the ratio, two line fits
   assign ratio    = sat_ff ? '1 : div_quo;
   assign inband   = (ratio >= R_LOW) && (ratio <= Q_ONE);
   assign r_ext    = SPO2_ACC_W'(ratio);
   assign acc      = inband ? BAND_BASE - r_ext * BAND_SLOPE : OUT_BASE - r_ext * OUT_SLOPE;
   assign spo2_int = acc[SPO2_ACC_W-1:FRAC_BITS];
   always_comb begin
      if (acc[SPO2_ACC_W-1] || (acc == '0)) begin
         spo2_in = '0;
      end else if (spo2_int > SPO2_INT_W'(SPO2_MAX)) begin
         spo2_in = SPO2_MAX;
      end else begin
         spo2_in = spo2_int[SPO2_BITS-1:0];
      end
   end

   // output slot
   assign rsp_valid_in = cmd.out_wr ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // block state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= NUM_RESET;
         red_max_ff   <= '0;
         red_min_ff   <= '0;
         ir_max_ff    <= '0;
         ir_min_ff    <= '0;
         prev_ff      <= '0;
         cnt_ff       <= '0;
         period_ff    <= '0;
         last_rate_ff <= '0;
         last_spo2_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            num_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            if (req_red_ac > red_max_ff) red_max_ff <= req_red_ac;
            if (req_red_ac < red_min_ff) red_min_ff <= req_red_ac;
            if (req_ir_ac > ir_max_ff) ir_max_ff <= req_ir_ac;
            if (req_ir_ac < ir_min_ff) ir_min_ff <= req_ir_ac;
            prev_ff <= req_red_ac;
            if (period_ff != '1) begin
               period_ff <= period_ff + COUNT_BITS'(1);
            end
         end
         if (cmd.spo2_wr) begin
            last_spo2_ff <= spo2_in;
         end
         if (cmd.cross_wr) begin
            cnt_ff <= (cnt_next == CROSS_CLOSE) ? CROSS_RESTART : cnt_next;
         end
         if (cmd.rate_wr) begin
            last_rate_ff <= sat_ff ? RATE_MAX : div_quo[RATE_BITS-1:0];
            period_ff    <= '0;
            red_max_ff   <= '0;
            red_min_ff   <= '0;
            ir_max_ff    <= '0;
            ir_min_ff    <= '0;
         end
      end
   end

   // per request working values
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rdc_ff   <= req_red_dc;
         idc_ff   <= req_ir_dc;
         cross_ff <= cross_in;
         upd_ff   <= 1'b0;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         den_ff  <= den_in;
         err_ff  <= err_in;
      end
      if (cmd.div_start) begin
         sat_ff <= sat_in;
      end
      if (cmd.rate_wr) begin
         upd_ff <= 1'b1;
      end
      if (cmd.out_wr) begin
         rsp_spo2_ff <= last_spo2_ff;
         rsp_rate_ff <= last_rate_ff;
         rsp_upd_ff  <= upd_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   // status to the controller
   assign stat.err      = err_ff;
   assign stat.close    = cnt_next == CROSS_CLOSE;
   assign stat.div_busy = div_busy;
   assign stat.div_done = div_done;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_spo2_percent = rsp_spo2_ff;
   assign rsp_heart_rate   = rsp_rate_ff;
   assign rsp_rate_updated = rsp_upd_ff;
   assign rsp_ratio_error  = rsp_err_ff;

endmodule

>>> rtl/core/pos_ctrl.sv
module pos_ctrl
   import pos_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  pos_stat_type stat,
   output pos_cmd_type  cmd
);

   pos_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_RDIV;
         end
         ST_RDIV: begin
            if (stat.err) begin
               state_in = ST_CROSS;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            if (stat.div_done) begin
               state_in = ST_SPO2;
            end
         end
         ST_SPO2: begin
            cmd.spo2_wr = 1'b1;
            state_in    = ST_CROSS;
         end
         ST_CROSS: begin
            cmd.cross_wr = 1'b1;
            if (stat.close) begin
               cmd.div_start = 1'b1;
               cmd.div_rate  = 1'b1;
               state_in      = ST_BWAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_BWAIT: begin
            if (stat.div_done) begin
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            cmd.rate_wr = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_wr = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
